// File: hw/rtl/mbtgl_pkg.sv
// Shared types and constants for the multibyte text glyph locator.
// Used by the front, queue, back and top-level modules; no dependencies.

package mbtgl_pkg;

  // Language mode codes
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_SJIS   = 2'd1;
  localparam logic [1:0] MODE_EUC    = 2'd2;
  localparam logic [1:0] MODE_GB     = 2'd3;

  // Font store offsets
  localparam logic [19:0] WIDE_BASE = 20'd4096;
  localparam logic [19:0] GB_EXTRA  = 20'd141376;  // 32 * 94 * 47
  localparam logic [15:0] CELLS_PER_ROW = 16'd94;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified glyph request
  typedef struct packed {
    logic        wide;
    logic        font;
    logic [1:0]  mode;
    logic [7:0]  lead;
    logic [7:0]  trail;
    logic [15:0] draw_x;
  } glyph_req_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hw/rtl/mbtgl_front.sv
// Front end: takes text bytes, tracks cursor, lead byte and language mode,
// and pushes classified glyph requests. Depends on mbtgl_pkg.

module mbtgl_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_data,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  logic [7:0]              code_byte,
  input  logic                    new_string,
  input  logic [11:0]             start_x,
  input  mbtgl_pkg::q_stat_t      q_stat,
  output logic                    q_push,
  output mbtgl_pkg::glyph_req_t   q_data
);

  logic [1:0]  mode;
  logic [7:0]  pending_lead;
  logic [15:0] cursor_x;

  logic        accept;
  logic [15:0] cursor_eff;
  logic        is_lead;
  logic        nonzero;
  logic        takes_lead;
  logic        pair;

  assign cfg_ready  = 1'b1;
  assign item_ready = !q_stat.full;
  assign accept     = item_valid && item_ready;

  // Cursor as seen by this byte
  assign cursor_eff = new_string ? {4'd0, start_x} : cursor_x;
  assign nonzero    = (code_byte != 8'd0);

  // Lead byte ranges per mode
  always_comb begin
    case (mode)
      mbtgl_pkg::MODE_SJIS: is_lead = code_byte inside {[8'h81:8'h9f], [8'he0:8'hfc]};
      mbtgl_pkg::MODE_EUC:  is_lead = code_byte inside {[8'h81:8'hfe]};
      mbtgl_pkg::MODE_GB:   is_lead = code_byte inside {[8'ha1:8'hfe]};
      default:              is_lead = 1'b0;
    endcase
  end

  assign pair       = (mode != mbtgl_pkg::MODE_SINGLE) && (pending_lead != 8'd0);
  assign takes_lead = (mode != mbtgl_pkg::MODE_SINGLE) && (pending_lead == 8'd0) && is_lead;

  // Request toward the back end
  assign q_push        = accept && nonzero && !takes_lead;
  assign q_data.wide   = pair;
  assign q_data.font   = pair || (mode == mbtgl_pkg::MODE_SJIS) || (mode == mbtgl_pkg::MODE_EUC);
  assign q_data.mode   = mode;
  assign q_data.lead   = pending_lead;
  assign q_data.trail  = code_byte;
  assign q_data.draw_x = pair ? (cursor_eff - 16'd8) : cursor_eff;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= mbtgl_pkg::MODE_SINGLE;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  // Cursor and lead byte state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= 16'd0;
      pending_lead <= 8'd0;
    end else if (accept) begin
      cursor_x <= nonzero ? (cursor_eff + 16'd8) : cursor_eff;
      if (nonzero && takes_lead) begin
        pending_lead <= code_byte;
      end else if (nonzero && pair) begin
        pending_lead <= 8'd0;
      end
    end
  end

endmodule

// File: hw/rtl/mbtgl_queue.sv
// Short request queue between the front and back ends.
// Depends on mbtgl_pkg for the entry type and depth.

module mbtgl_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  mbtgl_pkg::glyph_req_t   push_data,
  input  logic                    pop,
  output mbtgl_pkg::glyph_req_t   head,
  output mbtgl_pkg::q_stat_t      stat
);

  localparam logic [mbtgl_pkg::QPTR_W:0] FULL_COUNT =
    (mbtgl_pkg::QPTR_W + 1)'(mbtgl_pkg::QUEUE_DEPTH);

  mbtgl_pkg::glyph_req_t entries [mbtgl_pkg::QUEUE_DEPTH];
  logic [mbtgl_pkg::QPTR_W-1:0] wr_ptr;
  logic [mbtgl_pkg::QPTR_W-1:0] rd_ptr;
  logic [mbtgl_pkg::QPTR_W:0]   count;

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == FULL_COUNT);
  assign stat.empty = (count == '0);

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/mbtgl_back.sv
// Back end: turns a glyph request into a font offset and holds the
// result in an output register. Depends on mbtgl_pkg.

module mbtgl_back (
  input  logic                    clk,
  input  logic                    rst,
  input  mbtgl_pkg::glyph_req_t   req,
  input  mbtgl_pkg::q_stat_t      q_stat,
  output logic                    q_pop,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic signed [19:0]      glyph_offset,
  output logic                    font_select,
  output logic signed [15:0]      draw_x,
  output logic                    wide_glyph,
  output logic                    row_interleaved
);

  logic signed [9:0]  k;
  logic signed [9:0]  t;
  logic [9:0]         lead_w;
  logic [9:0]         trail_w;
  logic signed [15:0] k_w;
  logic signed [15:0] t_w;
  logic signed [15:0] idx;
  logic [19:0]        wide_off;
  logic [19:0]        offset;
  logic               is_gb;

  assign lead_w  = {2'd0, req.lead};
  assign trail_w = {2'd0, req.trail};
  assign is_gb   = (req.mode == mbtgl_pkg::MODE_GB);

  // Row (k) and cell (t) from the lead and trail pair
  always_comb begin
    if (req.mode == mbtgl_pkg::MODE_SJIS) begin
      if (req.lead inside {[8'h81:8'h9f]}) begin
        k = (lead_w - 10'd129) << 1;
      end else begin
        k = ((lead_w - 10'd224) << 1) + 10'd62;
      end
      if (req.trail inside {[8'h40:8'h7e]}) begin
        t = trail_w - 10'd64;
      end else if (req.trail inside {[8'h80:8'h9e]}) begin
        t = trail_w - 10'd65;
      end else begin
        t = trail_w - 10'd159;
        k = k + 10'd1;
      end
    end else begin
      k = lead_w - 10'd161;
      t = trail_w - 10'd161;
    end
  end

  // Glyph index times 32 plus the store base (and the GB extra in GB mode), wrapped to 20 bits
  assign k_w      = {{6{k[9]}}, k};
  assign t_w      = {{6{t[9]}}, t};
  assign idx      = k_w * $signed(mbtgl_pkg::CELLS_PER_ROW) + t_w;
  assign wide_off = {idx[14:0], 5'd0} + mbtgl_pkg::WIDE_BASE
                    + (is_gb ? mbtgl_pkg::GB_EXTRA : 20'd0);
  assign offset   = req.wide ? wide_off : {8'd0, req.trail, 4'd0};

  // Take the next request when the output register is free or draining
  assign q_pop = !q_stat.empty && (!result_valid || result_ready);

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (q_pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      glyph_offset    <= offset;
      font_select     <= req.font;
      draw_x          <= req.draw_x;
      wide_glyph      <= req.wide;
      row_interleaved <= req.wide && is_gb;
    end
  end

endmodule

// File: hw/rtl/multibyte_text_glyph_locator.sv
// Multibyte text glyph locator: one text byte in, at most one glyph
// request out, for half-width and full-width national fonts.
// Uses mbtgl_pkg, mbtgl_front, mbtgl_queue and mbtgl_back.
//
// Channels: item (code_byte, new_string, start_x) and result
// (glyph_offset, font_select, draw_x, wide_glyph, row_interleaved) use
// valid/ready; a transfer happens when both are high. cfg writes the
// 2-bit language mode and is always ready; write it only while idle.
// Throughput: one byte per cycle while the queue is not full. The front end updates cursor and lead
// byte in the accept cycle; the back end computes the offset (one constant
// multiply by 94 and adds) into the output register.
// Path: a byte's request is written into the queue, then popped into the output
// register, where the result is valid and can transfer out.
// Lead bytes and the 0x00 terminator produce no result.
// Stall: a two-entry queue plus the output register absorb results while
// result_ready is low; item_ready drops when the queue is full.
// Reset (rst, synchronous): mode 0, cursor 0, no lead pending, queue and
// output register empty.

module multibyte_text_glyph_locator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [7:0]         code_byte,
  input  logic               new_string,
  input  logic [11:0]        start_x,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [19:0] glyph_offset,
  output logic               font_select,
  output logic signed [15:0] draw_x,
  output logic               wide_glyph,
  output logic               row_interleaved
);

  mbtgl_pkg::glyph_req_t push_data;
  mbtgl_pkg::glyph_req_t head;
  mbtgl_pkg::q_stat_t    q_stat;
  logic                  q_push;
  logic                  q_pop;

  mbtgl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .code_byte  (code_byte),
    .new_string (new_string),
    .start_x    (start_x),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_data     (push_data)
  );

  mbtgl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .head      (head),
    .stat      (q_stat)
  );

  mbtgl_back u_back (
    .clk             (clk),
    .rst             (rst),
    .req             (head),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .glyph_offset    (glyph_offset),
    .font_select     (font_select),
    .draw_x          (draw_x),
    .wide_glyph      (wide_glyph),
    .row_interleaved (row_interleaved)
  );

`ifndef SYNTHESIS
  // Terminator byte never queues a request
  a_term_no_push: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && code_byte == 8'd0) |-> !q_push)
    else $error("terminator byte produced a glyph request");

  // Empty queue always admits a byte
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    q_stat.empty |-> item_ready)
    else $error("item_ready low with empty queue");

  // Wide glyphs come from the national store
  a_wide_font: assert property (@(posedge clk) disable iff (rst)
    (result_valid && wide_glyph) |-> font_select)
    else $error("wide glyph from half-width font");

  // Interleaving only applies to wide glyphs
  a_inter_wide: assert property (@(posedge clk) disable iff (rst)
    (result_valid && row_interleaved) |-> wide_glyph)
    else $error("row_interleaved set on half-width glyph");
`endif

endmodule
